/* sv/rme_pkg.sv */
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and constants of the rate matching engine: payload structs,
// configuration register map, mode bit positions and parity kind codes.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int SAMPLE_WIDTH = 8;
    localparam int VALUE_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int ERR_WIDTH    = 19;
    localparam int MAX_RUN      = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int MODE_W     = 6;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_E_INI_FIRST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_E_PLUS_FIRST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_E_MINUS_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_E_INI_SECOND   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_E_PLUS_SECOND  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_E_MINUS_SECOND = 3'd6;

    // register reset values
    localparam logic [MODE_W-1:0]     MODE_RST    = '0;
    localparam logic [CFG_DATA_W-1:0] E_INI_RST   = 18'd1;
    localparam logic [CFG_DATA_W-1:0] E_PLUS_RST  = 18'd1;
    localparam logic [CFG_DATA_W-1:0] E_MINUS_RST = 18'd0;

    // mode bits
    localparam int MODE_DEMATCH = 0;
    localparam int MODE_TURBO   = 1;
    localparam int MODE_REPEAT  = 2;
    localparam int MODE_PAR_LO  = 3;
    localparam int MODE_PAR_HI  = 4;
    localparam int MODE_ORDER   = 5;

    // parity kinds
    localparam logic [1:0] PAR_X  = 2'd0;
    localparam logic [1:0] PAR_Y  = 2'd1;
    localparam logic [1:0] PAR_YP = 2'd2;
    localparam logic [1:0] PAR_X3 = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           frame_start;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          inserted;
        logic                          last;
        logic                          error;
    } t_out;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [CFG_DATA_W-1:0] e_ini_first;
        logic [CFG_DATA_W-1:0] e_plus_first;
        logic [CFG_DATA_W-1:0] e_minus_first;
        logic [CFG_DATA_W-1:0] e_ini_second;
        logic [CFG_DATA_W-1:0] e_plus_second;
        logic [CFG_DATA_W-1:0] e_minus_second;
    } t_cfg;

endpackage

/* sv/rme_front.sv */
// ----------------------------------------------------------------------------
// rme_front
// Input side: takes requests and holds them in a short queue until the
// back end is ready to work on them.
// ----------------------------------------------------------------------------
module rme_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rme_pkg::t_in  i_in_data,
    output logic          o_q_valid,
    input  logic          i_q_pop,
    output rme_pkg::t_in  o_q_data
);

    rme_pkg::t_in                r_mem [rme_pkg::Q_DEPTH];
    logic [rme_pkg::Q_AW-1:0]    r_wptr;
    logic [rme_pkg::Q_AW-1:0]    r_rptr;
    logic [rme_pkg::Q_CW-1:0]    r_count;
    logic                        push;
    logic                        pop;

    assign o_in_ready = (r_count != rme_pkg::Q_CW'(rme_pkg::Q_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_data   = r_mem[r_rptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == rme_pkg::Q_AW'(rme_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == rme_pkg::Q_AW'(rme_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* sv/rme_back.sv */
// ----------------------------------------------------------------------------
// rme_back
// Back end: error counters, parity sequence and the per-sample sequencer
// that punctures, repeats, inserts zeros and sums repeats, with an output
// register toward the receiver.
// ----------------------------------------------------------------------------
module rme_back #(
    parameter int ERR_WIDTH = rme_pkg::ERR_WIDTH,
    parameter int MAX_RUN   = rme_pkg::MAX_RUN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rme_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  rme_pkg::t_in  i_q_data,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rme_pkg::t_out o_out_data
);

    localparam int CW    = ((ERR_WIDTH > rme_pkg::CFG_DATA_W + 1) ?
                            ERR_WIDTH : rme_pkg::CFG_DATA_W + 1) + 1;
    localparam int RUN_W = $clog2(MAX_RUN + 1);
    localparam int SW    = rme_pkg::SAMPLE_WIDTH;
    localparam int VW    = rme_pkg::VALUE_WIDTH;

    localparam logic signed [CW-1:0] EMAX = {{(CW-ERR_WIDTH+1){1'b0}}, {(ERR_WIDTH-1){1'b1}}};
    localparam logic signed [CW-1:0] EMIN = {{(CW-ERR_WIDTH+1){1'b1}}, {(ERR_WIDTH-1){1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUB   = 3'd1;
    localparam logic [2:0] S_ACT   = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_REP   = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;

    localparam logic [1:0] SEL_NONE   = 2'd0;
    localparam logic [1:0] SEL_FIRST  = 2'd1;
    localparam logic [1:0] SEL_SECOND = 2'd2;

    function automatic logic signed [ERR_WIDTH-1:0] sat_err(input logic signed [CW-1:0] v);
        if (v > EMAX) begin
            return EMAX[ERR_WIDTH-1:0];
        end else if (v < EMIN) begin
            return EMIN[ERR_WIDTH-1:0];
        end
        return v[ERR_WIDTH-1:0];
    endfunction

    function automatic logic signed [CW-1:0] ext_u(input logic [rme_pkg::CFG_DATA_W-1:0] v);
        return signed'({{(CW-rme_pkg::CFG_DATA_W){1'b0}}, v});
    endfunction

    function automatic rme_pkg::t_out mk_out(input logic signed [VW-1:0] v, input logic ins,
                                             input logic last, input logic err);
        rme_pkg::t_out o;
        o.value    = v;
        o.inserted = ins;
        o.last     = last;
        o.error    = err;
        return o;
    endfunction

    logic [2:0]                   r_state, n_state;
    logic signed [ERR_WIDTH-1:0]  r_e1, n_e1;
    logic signed [ERR_WIDTH-1:0]  r_e2, n_e2;
    logic [1:0]                   r_par, n_par;
    logic signed [ERR_WIDTH-1:0]  r_diff, n_diff;
    logic [1:0]                   r_sel, n_sel;
    logic signed [SW-1:0]         r_s, n_s;
    logic signed [SW-1:0]         r_held, n_held;
    logic                         r_holding, n_holding;
    logic [RUN_W-1:0]             r_run, n_run;
    logic                         r_pend, n_pend;
    logic                         r_fin_err, n_fin_err;
    logic                         r_out_valid, n_out_valid;
    rme_pkg::t_out                r_out, n_out;

    logic                         out_free;
    logic                         done;
    logic                         dem;
    logic                         turbo;
    logic                         hit;
    logic [1:0]                   first_par;
    logic [rme_pkg::CFG_DATA_W-1:0] add_p;
    logic signed [ERR_WIDTH-1:0]  e_new;
    logic signed [VW-1:0]         s_ext;

    assign out_free    = !r_out_valid || i_out_ready;
    assign dem         = i_cfg.mode[rme_pkg::MODE_DEMATCH];
    assign turbo       = i_cfg.mode[rme_pkg::MODE_TURBO];
    assign first_par   = (i_cfg.mode[rme_pkg::MODE_PAR_HI:rme_pkg::MODE_PAR_LO] == rme_pkg::PAR_X3)
                         ? rme_pkg::PAR_X
                         : i_cfg.mode[rme_pkg::MODE_PAR_HI:rme_pkg::MODE_PAR_LO];
    assign s_ext       = VW'(r_s);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // counter operands
    always_comb begin
        add_p = (r_sel == SEL_SECOND) ? i_cfg.e_plus_second : i_cfg.e_plus_first;
        hit   = (r_sel != SEL_NONE) && (r_diff[ERR_WIDTH-1] || (r_diff == '0));
        e_new = hit ? sat_err(CW'(r_diff) + ext_u(add_p)) : r_diff;
    end

    always_comb begin
        logic [1:0] p;
        logic [1:0] sel;
        n_state     = r_state;
        n_e1        = r_e1;
        n_e2        = r_e2;
        n_par       = r_par;
        n_diff      = r_diff;
        n_sel       = r_sel;
        n_s         = r_s;
        n_held      = r_held;
        n_holding   = r_holding;
        n_run       = r_run;
        n_pend      = r_pend;
        n_fin_err   = r_fin_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        done        = 1'b0;
        o_q_pop     = 1'b0;
        p           = r_par;
        sel         = SEL_FIRST;

        unique case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_SUB: begin
                if (turbo) begin
                    if (p == rme_pkg::PAR_Y) begin
                        sel = SEL_FIRST;
                    end else if (p == rme_pkg::PAR_YP) begin
                        sel = SEL_SECOND;
                    end else begin
                        sel = SEL_NONE;
                    end
                    if (i_cfg.mode[rme_pkg::MODE_ORDER]) begin
                        n_par = (p == rme_pkg::PAR_X) ? rme_pkg::PAR_YP :
                                (p == rme_pkg::PAR_YP) ? rme_pkg::PAR_Y : rme_pkg::PAR_X;
                    end else begin
                        n_par = (p == rme_pkg::PAR_X) ? rme_pkg::PAR_Y :
                                (p == rme_pkg::PAR_Y) ? rme_pkg::PAR_YP : rme_pkg::PAR_X;
                    end
                end
                n_sel = sel;
                if (sel == SEL_SECOND) begin
                    n_diff = sat_err(CW'(r_e2) - ext_u(i_cfg.e_minus_second));
                end else begin
                    n_diff = sat_err(CW'(r_e1) - ext_u(i_cfg.e_minus_first));
                end
                n_state = S_ACT;
            end
            S_ACT: begin
                if (out_free) begin
                    if (r_sel == SEL_FIRST) begin
                        n_e1 = e_new;
                    end else if (r_sel == SEL_SECOND) begin
                        n_e2 = e_new;
                    end
                    if (!dem) begin
                        if (!hit) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_out(s_ext, 1'b0, 1'b1, 1'b0);
                            done        = 1'b1;
                        end else if (!turbo && i_cfg.mode[rme_pkg::MODE_REPEAT]) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_out(s_ext, 1'b0, 1'b0, 1'b0);
                            n_state     = S_REP;
                        end else begin
                            done = 1'b1;
                        end
                    end else if (hit && !turbo && i_cfg.mode[rme_pkg::MODE_REPEAT]) begin
                        // repeat waits for its second copy
                        n_held    = r_s;
                        n_holding = 1'b1;
                        if (r_pend) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_out('0, 1'b1, 1'b1, 1'b0);
                        end
                        done = 1'b1;
                    end else if (hit && (r_run < RUN_W'(MAX_RUN))) begin
                        // inserted zero, held back until the next position is known
                        if (r_pend) begin
                            n_out_valid = 1'b1;
                            n_out       = mk_out('0, 1'b1, 1'b0, 1'b0);
                        end
                        n_pend  = 1'b1;
                        n_run   = r_run + 1'b1;
                        n_state = S_SUB;
                    end else begin
                        n_out_valid = 1'b1;
                        if (r_pend) begin
                            n_out     = mk_out('0, 1'b1, 1'b0, 1'b0);
                            n_fin_err = hit;
                            n_state   = S_FINAL;
                        end else begin
                            n_out = mk_out(s_ext, 1'b0, 1'b1, hit);
                            done  = 1'b1;
                        end
                    end
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = mk_out(s_ext, 1'b0, 1'b1, r_fin_err);
                    done        = 1'b1;
                end
            end
            S_REP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = mk_out(s_ext, 1'b0, 1'b1, 1'b0);
                    done        = 1'b1;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = mk_out(VW'(r_held) + s_ext, 1'b0, 1'b1, 1'b0);
                    n_holding   = 1'b0;
                    done        = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            n_state = S_IDLE;
        end

        // start of the next request
        if (((r_state == S_IDLE) || done) && i_q_valid) begin
            o_q_pop   = 1'b1;
            n_s       = i_q_data.sample;
            n_run     = '0;
            n_pend    = 1'b0;
            n_fin_err = 1'b0;
            if (i_q_data.frame_start) begin
                n_e1      = sat_err(ext_u(i_cfg.e_ini_first));
                n_e2      = sat_err(ext_u(i_cfg.e_ini_second));
                n_par     = first_par;
                n_holding = 1'b0;
            end
            if (dem && n_holding) begin
                n_state = S_SUM;
            end else begin
                if (!dem) begin
                    n_holding = 1'b0;
                end
                n_state = S_SUB;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff    <= n_diff;
        r_s       <= n_s;
        r_held    <= n_held;
        r_run     <= n_run;
        r_fin_err <= n_fin_err;
        r_out     <= n_out;
        r_sel     <= n_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_e1        <= ERR_WIDTH'(rme_pkg::E_INI_RST);
            r_e2        <= ERR_WIDTH'(rme_pkg::E_INI_RST);
            r_par       <= rme_pkg::PAR_X;
            r_holding   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_e1        <= n_e1;
            r_e2        <= n_e2;
            r_par       <= n_par;
            r_holding   <= n_holding;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* sv/rate_matching_engine.sv */
// ----------------------------------------------------------------------------
// rate_matching_engine
// Puncture / repeat rate matcher and dematcher driven by error counters.
//
// Input requests carry one soft sample and a frame-start flag; frame start
// reloads the counters from the e_ini registers and the parity sequence from
// the mode bits. Output requests carry value, inserted, last and error; last
// marks the final result of one input sample. A sample may give no result
// (match puncture, dematch repeat waiting for its copy) or up to MAX_RUN+1.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Input requests wait in a two-entry queue; the back end
// evaluates each counter position by a subtract step, then a decide and
// update step. A plain sample takes one position, each inserted zero one
// more, and the result after a zero run or a match repeat copy takes a
// further state; a dematch sum evaluates no position.
// Results sit in an output register; while the receiver stalls the back end
// holds, and the queue keeps taking requests until full.
// Reset clears queue and output, loads register reset values and sets the
// counters to the reset e_ini values.
// ----------------------------------------------------------------------------
module rate_matching_engine #(
    parameter int ERR_WIDTH = rme_pkg::ERR_WIDTH,
    parameter int MAX_RUN   = rme_pkg::MAX_RUN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rme_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rme_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [rme_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rme_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    rme_pkg::t_cfg r_cfg;
    logic          q_valid;
    logic          q_pop;
    rme_pkg::t_in  q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= rme_pkg::MODE_RST;
            r_cfg.e_ini_first    <= rme_pkg::E_INI_RST;
            r_cfg.e_plus_first   <= rme_pkg::E_PLUS_RST;
            r_cfg.e_minus_first  <= rme_pkg::E_MINUS_RST;
            r_cfg.e_ini_second   <= rme_pkg::E_INI_RST;
            r_cfg.e_plus_second  <= rme_pkg::E_PLUS_RST;
            r_cfg.e_minus_second <= rme_pkg::E_MINUS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rme_pkg::CFG_MODE: begin
                    r_cfg.mode <= i_cfg_data[rme_pkg::MODE_W-1:0];
                end
                rme_pkg::CFG_E_INI_FIRST: begin
                    r_cfg.e_ini_first <= i_cfg_data;
                end
                rme_pkg::CFG_E_PLUS_FIRST: begin
                    r_cfg.e_plus_first <= i_cfg_data;
                end
                rme_pkg::CFG_E_MINUS_FIRST: begin
                    r_cfg.e_minus_first <= i_cfg_data;
                end
                rme_pkg::CFG_E_INI_SECOND: begin
                    r_cfg.e_ini_second <= i_cfg_data;
                end
                rme_pkg::CFG_E_PLUS_SECOND: begin
                    r_cfg.e_plus_second <= i_cfg_data;
                end
                rme_pkg::CFG_E_MINUS_SECOND: begin
                    r_cfg.e_minus_second <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    rme_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_data   (q_data)
    );

    rme_back #(
        .ERR_WIDTH (ERR_WIDTH),
        .MAX_RUN   (MAX_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
